// ----- rtl/hsv2rgb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, limits and hue sector codes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Fixed field widths
  localparam int IN_W  = 18;
  localparam int OUT_W = 17;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef logic [2:0] sector_t;

  // Hue sectors, in order around the wheel
  localparam sector_t SECT_RED_YEL = 3'd0;
  localparam sector_t SECT_YEL_GRN = 3'd1;
  localparam sector_t SECT_GRN_CYN = 3'd2;
  localparam sector_t SECT_CYN_BLU = 3'd3;
  localparam sector_t SECT_BLU_MAG = 3'd4;
  localparam sector_t SECT_MAG_RED = 3'd5;

endpackage

// ----- rtl/hsv2rgb_clamp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_clamp
// Stage 1: clamps hue, saturation and value to 0..ONE and registers them.
// ----------------------------------------------------------------------------
module hsv2rgb_clamp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]   hue_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]   sat_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]   val_i,
  output logic                           valid_o,
  output logic [FRAC_BITS:0]             hue_o,
  output logic [FRAC_BITS:0]             sat_o,
  output logic [FRAC_BITS:0]             val_o
);
  import hsv2rgb_pkg::*;

  localparam int CW   = FRAC_BITS + 1;
  localparam int CMPW = (CW > IN_W) ? CW : IN_W;

  localparam logic [CMPW-1:0] ONE_EXT = CMPW'(1) << FRAC_BITS;

  function automatic logic [CW-1:0] clamp_unit(input logic [IN_W-1:0] raw);
    logic [CMPW-1:0] ext;
    ext = CMPW'(raw);
    if (raw[IN_W-1]) begin
      clamp_unit = '0;
    end else if (ext > ONE_EXT) begin
      clamp_unit = ONE_EXT[CW-1:0];
    end else begin
      clamp_unit = ext[CW-1:0];
    end
  endfunction

  logic          valid_q;
  logic [CW-1:0] hue_q, sat_q, val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= clamp_unit(hue_i);
      sat_q <= clamp_unit(sat_i);
      val_q <= clamp_unit(val_i);
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

endmodule

// ----- rtl/hsv2rgb_chroma.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_chroma
// Stage 2: chroma c = v*s, hue sector and the weight ONE - |hp mod 2 - 1|.
// ----------------------------------------------------------------------------
module hsv2rgb_chroma #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [FRAC_BITS:0]    hue_i,
  input  logic [FRAC_BITS:0]    sat_i,
  input  logic [FRAC_BITS:0]    val_i,
  output logic                  valid_o,
  output logic [FRAC_BITS:0]    chroma_o,
  output logic [FRAC_BITS:0]    val_o,
  output logic [FRAC_BITS:0]    weight_o,
  output hsv2rgb_pkg::sector_t  sector_o
);
  import hsv2rgb_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam int HW = CW + 3;

  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  logic [2*CW-1:0] prod;
  logic [HW-1:0]   hp;
  logic [3:0]      sect_raw;
  logic [CW-1:0]   frac2;    // hp mod 2*ONE
  logic [CW-1:0]   hue_dev;
  sector_t         sector_d;

  always_comb begin
    prod     = sat_i * val_i;
    hp       = HW'(hue_i) * HW'(6);
    sect_raw = hp[HW-1:FRAC_BITS];
    frac2    = hp[FRAC_BITS:0];
    hue_dev  = (frac2 >= ONE) ? (frac2 - ONE) : (ONE - frac2);
    // hue of exactly one lands in sector 6; fold into the last sector
    sector_d = (sect_raw > 4'(SECT_MAG_RED)) ? SECT_MAG_RED : sect_raw[2:0];
  end

  logic          valid_q;
  logic [CW-1:0] chroma_q, val_q, weight_q;
  sector_t       sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chroma_q <= prod[FRAC_BITS +: CW];
      val_q    <= val_i;
      weight_q <= ONE - hue_dev;
      sector_q <= sector_d;
    end
  end

  assign valid_o  = valid_q;
  assign chroma_o = chroma_q;
  assign val_o    = val_q;
  assign weight_o = weight_q;
  assign sector_o = sector_q;

endmodule

// ----- rtl/hsv2rgb_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stage 3: second component x = c*weight and offset m = v - c.
// ----------------------------------------------------------------------------
module hsv2rgb_mix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [FRAC_BITS:0]    chroma_i,
  input  logic [FRAC_BITS:0]    val_i,
  input  logic [FRAC_BITS:0]    weight_i,
  input  hsv2rgb_pkg::sector_t  sector_i,
  output logic                  valid_o,
  output logic [FRAC_BITS:0]    chroma_o,
  output logic [FRAC_BITS:0]    second_o,
  output logic [FRAC_BITS:0]    offset_o,
  output hsv2rgb_pkg::sector_t  sector_o
);
  import hsv2rgb_pkg::*;

  localparam int CW = FRAC_BITS + 1;

  logic [2*CW-1:0] prod;

  assign prod = chroma_i * weight_i;

  logic          valid_q;
  logic [CW-1:0] chroma_q, second_q, offset_q;
  sector_t       sector_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chroma_q <= chroma_i;
      second_q <= prod[FRAC_BITS +: CW];
      offset_q <= val_i - chroma_i;  // c <= v, never negative
      sector_q <= sector_i;
    end
  end

  assign valid_o  = valid_q;
  assign chroma_o = chroma_q;
  assign second_o = second_q;
  assign offset_o = offset_q;
  assign sector_o = sector_q;

endmodule

// ----- rtl/hsv2rgb_place.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_place
// Stage 4: routes c and x to channels by sector, adds m, saturates, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_place #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [FRAC_BITS:0]              chroma_i,
  input  logic [FRAC_BITS:0]              second_i,
  input  logic [FRAC_BITS:0]              offset_i,
  input  hsv2rgb_pkg::sector_t            sector_i,
  output logic                            valid_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]   red_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]   green_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]   blue_o
);
  import hsv2rgb_pkg::*;

  localparam int CW = FRAC_BITS + 1;
  localparam int SW = (CW + 1 > OUT_W) ? CW + 1 : OUT_W;

  function automatic logic [OUT_W-1:0] add_sat(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
    logic [SW-1:0] sum;
    sum = SW'(a) + SW'(b);
    add_sat = (sum > SW'(OUT_MAX)) ? OUT_MAX : sum[OUT_W-1:0];
  endfunction

  logic [CW-1:0] r1, g1, b1;

  always_comb begin
    case (sector_i)
      SECT_RED_YEL: begin r1 = chroma_i; g1 = second_i; b1 = '0;       end
      SECT_YEL_GRN: begin r1 = second_i; g1 = chroma_i; b1 = '0;       end
      SECT_GRN_CYN: begin r1 = '0;       g1 = chroma_i; b1 = second_i; end
      SECT_CYN_BLU: begin r1 = '0;       g1 = second_i; b1 = chroma_i; end
      SECT_BLU_MAG: begin r1 = second_i; g1 = '0;       b1 = chroma_i; end
      default:      begin r1 = chroma_i; g1 = '0;       b1 = second_i; end
    endcase
  end

  logic             valid_q;
  logic [OUT_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= add_sat(r1, offset_i);
      green_q <= add_sat(g1, offset_i);
      blue_q  <= add_sat(b1, offset_i);
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ----- rtl/hsv_to_rgb_converter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Fixed-point HSV to RGB pixel converter, four-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, as long as the output side does not stall, and
// passes it through the clamp, chroma, mix and place stages. Hue, saturation
// and value are signed fixed point with FRAC_BITS fraction bits (ONE =
// 2**FRAC_BITS is 1.0), each clamped to 0..ONE; red, green and blue come out
// in the same scale, saturating at the 17-bit maximum. The two multipliers
// (chroma v*s, then x = c*weight) are each given a stage of their own, with
// a clamp stage before and a placement/add stage after. All
// stages advance together: a stall on the output holds the whole pipeline,
// and stall_o is raised only while a finished pixel waits at the output, so
// no pixel is lost or repeated. Products are truncated, never rounded.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top #(
  parameter int FRAC_BITS = 16  // 8..24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel in
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [hsv2rgb_pkg::IN_W-1:0]  hue_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::IN_W-1:0]  brightness_i,
  // pixel out
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [hsv2rgb_pkg::OUT_W-1:0] red_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0] green_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0] blue_o
);
  import hsv2rgb_pkg::*;

  localparam int CW = FRAC_BITS + 1;

  // Largest legal channel value: ONE, or the 17-bit limit when ONE is wider
  localparam int LW = (CW > OUT_W) ? CW : OUT_W;
  localparam logic [LW-1:0] ONE_LW  = LW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] OUT_LIM = (ONE_LW > LW'(OUT_MAX)) ? LW'(OUT_MAX) : ONE_LW;

  // Global advance: everything moves unless a finished pixel is held up.
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // Stage 1 -> 2
  logic          s1_valid;
  logic [CW-1:0] s1_hue, s1_sat, s1_val;
  // Stage 2 -> 3
  logic          s2_valid;
  logic [CW-1:0] s2_chroma, s2_val, s2_weight;
  sector_t       s2_sector;
  // Stage 3 -> 4
  logic          s3_valid;
  logic [CW-1:0] s3_chroma, s3_second, s3_offset;
  sector_t       s3_sector;

  hsv2rgb_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .hue_i   (hue_i),
    .sat_i   (saturation_i),
    .val_i   (brightness_i),
    .valid_o (s1_valid),
    .hue_o   (s1_hue),
    .sat_o   (s1_sat),
    .val_o   (s1_val)
  );

  hsv2rgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s1_valid),
    .hue_i    (s1_hue),
    .sat_i    (s1_sat),
    .val_i    (s1_val),
    .valid_o  (s2_valid),
    .chroma_o (s2_chroma),
    .val_o    (s2_val),
    .weight_o (s2_weight),
    .sector_o (s2_sector)
  );

  hsv2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s2_valid),
    .chroma_i (s2_chroma),
    .val_i    (s2_val),
    .weight_i (s2_weight),
    .sector_i (s2_sector),
    .valid_o  (s3_valid),
    .chroma_o (s3_chroma),
    .second_o (s3_second),
    .offset_o (s3_offset),
    .sector_o (s3_sector)
  );

  hsv2rgb_place #(.FRAC_BITS(FRAC_BITS)) u_place (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s3_valid),
    .chroma_i (s3_chroma),
    .second_i (s3_second),
    .offset_i (s3_offset),
    .sector_i (s3_sector),
    .valid_o  (valid_o),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input is held off only by a waiting output pixel.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o raised without a held output pixel");

  // A pixel taken in reaches the output if no stall holds it on the way.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) ##1 !stall_o ##1 !stall_o ##1 !stall_o |=> valid_o)
    else $error("accepted pixel did not reach the output");

  // Channels never exceed full intensity.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (LW'(red_o) <= OUT_LIM && LW'(green_o) <= OUT_LIM &&
                 LW'(blue_o) <= OUT_LIM))
    else $error("output channel above full intensity");

endmodule
